@@ design/slrv_pkg.sv @@
package slrv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int VOL_W       = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 2'd3;

    localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;

    // results per source frame
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    // lane pipeline depth, issue register to output register
    localparam int LANE_LAT = 6;

    // |sample * volume| after dropping the fraction is below 2^23
    localparam int QUO_W     = 23;
    // floor(q / 100) = (q * ceil(2^30 / 100)) >> 30, exact for q < 2^23
    localparam int DIV_MUL_W = 24;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd10737419;
    localparam int DIV_SHIFT = 30;
    // quotient magnitude is at most 32768 * 127 / 100
    localparam int QUO_OUT_W = 17;

    localparam logic [QUO_OUT_W-1:0] SAT_POS_MAG = 17'd32767;
    localparam logic [QUO_OUT_W-1:0] SAT_NEG_MAG = 17'd32768;

    typedef struct packed {
        logic             en;
        logic [VOL_W-1:0] vol;
    } t_lane_ctl;

endpackage

@@ design/slrv_lane.sv @@
// One channel: lerp, volume multiply, divide by 100*ONE toward zero, saturate.
module slrv_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  slrv_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [slrv_pkg::SAMPLE_W-1:0]  i_prev,
    input  logic signed [slrv_pkg::SAMPLE_W-1:0]  i_cur,
    input  logic        [FRAC_BITS-1:0]           i_frac,
    output logic signed [slrv_pkg::SAMPLE_W-1:0]  o_sample
);

    localparam int SW     = slrv_pkg::SAMPLE_W;
    localparam int LERP_W = SW + FRAC_BITS + 2;
    localparam int NUM_W  = LERP_W + slrv_pkg::VOL_W + 1;
    localparam int QW     = slrv_pkg::QUO_W;
    localparam int PRD_W  = slrv_pkg::QUO_W + slrv_pkg::DIV_MUL_W;
    localparam int OW     = slrv_pkg::QUO_OUT_W;

    logic signed [SW:0]        w_diff;
    logic        [NUM_W-1:0]   w_mag;
    logic        [OW-1:0]      w_quo;
    logic        [OW-1:0]      w_neg;
    logic signed [SW-1:0]      n_out;

    logic signed [LERP_W-1:0]  r_prod;
    logic signed [SW-1:0]      r_prev_a;
    logic signed [LERP_W-1:0]  r_lerp;
    logic signed [NUM_W-1:0]   r_num;
    logic        [QW-1:0]      r_q;
    logic                      r_neg_d;
    logic        [PRD_W-1:0]   r_quo_prod;
    logic                      r_neg_e;
    logic signed [SW-1:0]      r_out;

    assign w_diff = (SW+1)'(i_cur) - (SW+1)'(i_prev);
    assign w_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_quo  = r_quo_prod[slrv_pkg::DIV_SHIFT +: OW];
    assign w_neg  = OW'(0) - w_quo;

    always_comb begin
        if (r_neg_e) begin
            if (w_quo > slrv_pkg::SAT_NEG_MAG) begin
                n_out = $signed(slrv_pkg::SAT_NEG_MAG[SW-1:0]);
            end else begin
                n_out = $signed(w_neg[SW-1:0]);
            end
        end else begin
            if (w_quo > slrv_pkg::SAT_POS_MAG) begin
                n_out = $signed(slrv_pkg::SAT_POS_MAG[SW-1:0]);
            end else begin
                n_out = $signed(w_quo[SW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // (cur - prev) * phase fraction
            r_prod     <= LERP_W'(w_diff) * LERP_W'($signed({1'b0, i_frac}));
            r_prev_a   <= i_prev;
            // prev * ONE + product
            r_lerp     <= (LERP_W'(r_prev_a) <<< FRAC_BITS) + r_prod;
            r_num      <= NUM_W'(r_lerp) * NUM_W'($signed({1'b0, i_ctl.vol}));
            // truncation toward zero works on the magnitude
            r_q        <= w_mag[FRAC_BITS +: QW];
            r_neg_d    <= r_num[NUM_W-1];
            r_quo_prod <= PRD_W'(r_q) * PRD_W'(slrv_pkg::DIV_MUL);
            r_neg_e    <= r_neg_d;
            r_out      <= n_out;
        end
    end

    assign o_sample = r_out;

endmodule

@@ design/stereo_linear_resampler_volume_unit.sv @@
// A taken request runs through the sequencer, the issue register and the lane stages.
// The input stays stalled while the sequencer works on a frame: one issue per result for a
// resampled frame, then the phase update; bypass issues one result, mute takes and drops the frame.
// The per-result sequencer issues into two 6-stage lane pipelines; a stalled output freezes them.
// Reset (synchronous, active low): registers to their defaults, phase = ONE, prev frame = 0,
// sequencer idle, pipeline empty.
module stereo_linear_resampler_volume_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // source frames
    input  logic                                  i_src_valid,
    output logic                                  o_src_stall,
    input  logic signed [slrv_pkg::SAMPLE_W-1:0]  i_src_left,
    input  logic signed [slrv_pkg::SAMPLE_W-1:0]  i_src_right,
    input  logic                                  i_chunk_last,
    // result frames
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [slrv_pkg::SAMPLE_W-1:0]  o_out_left,
    output logic signed [slrv_pkg::SAMPLE_W-1:0]  o_out_right,
    output logic                                  o_run_last,
    // register writes
    input  logic                                  i_cfg_we,
    input  logic [slrv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [FRAC_BITS+4:0]                  i_cfg_data
);

    // phase and step: FRAC_BITS fraction bits, five integer bits
    localparam int PW = FRAC_BITS + 5;
    localparam int SW = slrv_pkg::SAMPLE_W;
    localparam int LAT = slrv_pkg::LANE_LAT;
    localparam int CW = slrv_pkg::CNT_W;

    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] STEP_MIN  = PW'(1) << (FRAC_BITS - 4);
    localparam logic [PW-1:0] STEP_MAX  = PW'(1) << (FRAC_BITS + 4);

    localparam logic [CW-1:0] CNT_MAX  = CW'(slrv_pkg::MAX_RESULTS);
    localparam logic [CW-1:0] CNT_LAST = CW'(slrv_pkg::MAX_RESULTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration
    logic [PW-1:0]               r_step;
    logic                        r_bypass;
    logic [slrv_pkg::VOL_W-1:0]  r_vol;
    logic                        r_mute;

    // sequencer
    logic                        r_state;
    logic [CW-1:0]               r_cnt;
    logic [PW-1:0]               r_phase;
    logic signed [SW-1:0]        r_prev_l;
    logic signed [SW-1:0]        r_prev_r;
    logic signed [SW-1:0]        r_cur_l;
    logic signed [SW-1:0]        r_cur_r;

    // issue register feeding both lanes
    logic                        r_iss_valid;
    logic                        r_iss_last;
    logic signed [SW-1:0]        r_iss_prev_l;
    logic signed [SW-1:0]        r_iss_prev_r;
    logic signed [SW-1:0]        r_iss_cur_l;
    logic signed [SW-1:0]        r_iss_cur_r;
    logic [FRAC_BITS-1:0]        r_iss_frac;

    // valid / run_last travel alongside the lane stages
    logic [LAT-1:0]              r_vld_pipe;
    logic [LAT-1:0]              r_last_pipe;

    logic                        w_accept;
    logic                        w_adv;
    logic [PW-1:0]               w_step;
    logic [PW-1:0]               w_phase_sum;
    logic                        w_phase_lo;
    logic                        w_more;
    logic                        w_issue;
    logic                        w_issue_last;
    slrv_pkg::t_lane_ctl         w_ctl;

    assign o_src_stall = (r_state == ST_RUN);
    assign w_accept    = i_src_valid && !o_src_stall;

    // whole pipeline moves unless a finished result is held by a stall
    assign w_adv = !(o_out_valid && i_out_stall);

    // step is clamped to ONE/16 .. 16*ONE, so at most 16 results per frame
    always_comb begin
        priority if (r_step < STEP_MIN) begin
            w_step = STEP_MIN;
        end else if (r_step > STEP_MAX) begin
            w_step = STEP_MAX;
        end else begin
            w_step = r_step;
        end
    end

    assign w_phase_sum  = r_phase + w_step;
    assign w_phase_lo   = (r_phase < PHASE_ONE);
    assign w_more       = w_phase_lo && (r_cnt < CNT_MAX);
    assign w_issue      = (r_state == ST_RUN) && w_adv && (r_bypass || w_more);
    assign w_issue_last = r_bypass || (w_phase_sum >= PHASE_ONE) || (r_cnt == CNT_LAST);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= PHASE_ONE;
            r_bypass <= 1'b1;
            r_vol    <= slrv_pkg::VOL_RESET;
            r_mute   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slrv_pkg::CFG_STEP:   r_step   <= i_cfg_data;
                slrv_pkg::CFG_BYPASS: r_bypass <= i_cfg_data[0];
                slrv_pkg::CFG_VOLUME: r_vol    <= i_cfg_data[slrv_pkg::VOL_W-1:0];
                slrv_pkg::CFG_MUTE:   r_mute   <= i_cfg_data[0];
                default:              r_mute   <= r_mute;
            endcase
        end
    end

    // frame sequencer: one issue per result, then the phase update; bypass issues once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_phase  <= PHASE_ONE;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // muted frames are taken and dropped
                    if (w_accept && !r_mute) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_bypass) begin
                        // volume only; phase and prev frame untouched
                        if (w_adv) begin
                            r_state <= ST_IDLE;
                        end
                    end else if (w_more) begin
                        if (w_adv) begin
                            r_phase <= w_phase_sum;
                            r_cnt   <= r_cnt + CW'(1);
                        end
                    end else begin
                        r_phase  <= (r_phase >= PHASE_ONE) ? (r_phase - PHASE_ONE) : '0;
                        r_prev_l <= r_cur_l;
                        r_prev_r <= r_cur_r;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // current frame; chunk_last has no effect on results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_l <= i_src_left;
            r_cur_r <= i_src_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
            r_vld_pipe  <= '0;
        end else if (w_adv) begin
            r_iss_valid <= w_issue;
            r_vld_pipe  <= {r_vld_pipe[LAT-2:0], r_iss_valid};
        end
    end

    // bypass reuses the lerp with prev = cur, which yields cur * ONE
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_iss_last   <= w_issue_last;
            r_iss_prev_l <= r_bypass ? r_cur_l : r_prev_l;
            r_iss_prev_r <= r_bypass ? r_cur_r : r_prev_r;
            r_iss_cur_l  <= r_cur_l;
            r_iss_cur_r  <= r_cur_r;
            r_iss_frac   <= r_bypass ? '0 : r_phase[FRAC_BITS-1:0];
            r_last_pipe  <= {r_last_pipe[LAT-2:0], r_iss_last};
        end
    end

    assign w_ctl.en  = w_adv;
    assign w_ctl.vol = r_vol;

    slrv_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_prev   (r_iss_prev_l),
        .i_cur    (r_iss_cur_l),
        .i_frac   (r_iss_frac),
        .o_sample (o_out_left)
    );

    slrv_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_prev   (r_iss_prev_r),
        .i_cur    (r_iss_cur_r),
        .i_frac   (r_iss_frac),
        .o_sample (o_out_right)
    );

    // lane output registers and the sideband stage form the result frame
    assign o_out_valid = r_vld_pipe[LAT-1];
    assign o_run_last  = r_last_pipe[LAT-1];

endmodule

@@ tb/tb_stereo_linear_resampler_volume_unit.sv @@
`timescale 1ns / 1ps

module tb_stereo_linear_resampler_volume_unit;

    localparam int FRAC_BITS = 16;
    localparam longint UNITY = longint'(1) << FRAC_BITS;
    localparam longint STEP_FLOOR = UNITY >> 4;   // slowest step the block honors
    localparam longint STEP_CEIL = UNITY << 4;    // fastest step the block honors
    localparam int UNITY_I = 1 << FRAC_BITS;

    // slack after the last expected result, for anything still in the pipeline
    localparam int SETTLE_CYCLES = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BLOCKS_PER_PHASE = 4;
    localparam int FRAMES_PER_BLOCK = 16;

    typedef logic signed [slrv_pkg::SAMPLE_W-1:0] t_sample;
    typedef logic [FRAC_BITS+4:0] t_cfg_word;

    typedef struct {
        t_sample left;
        t_sample right;
        logic run_last;
    } t_out_frame;

    // ---------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_src_valid = 1'b0;
    logic o_src_stall;
    t_sample i_src_left = '0;
    t_sample i_src_right = '0;
    logic i_chunk_last = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_sample o_out_left;
    t_sample o_out_right;
    logic o_run_last;
    logic i_cfg_we = 1'b0;
    logic [slrv_pkg::CFG_IDX_W-1:0] i_cfg_index = slrv_pkg::CFG_STEP;
    t_cfg_word i_cfg_data = '0;

    stereo_linear_resampler_volume_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_src_valid(i_src_valid),
        .o_src_stall(o_src_stall),
        .i_src_left(i_src_left),
        .i_src_right(i_src_right),
        .i_chunk_last(i_chunk_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_left(o_out_left),
        .o_out_right(o_out_right),
        .o_run_last(o_run_last),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow of the block: registers and resampler state.
    // Values after reset match the block's defaults.
    // ---------------------------------------------------------------
    longint step_shadow = 65536;
    bit bypass_shadow = 1'b1;
    int volume_shadow = 100;
    bit mute_shadow = 1'b0;
    int last_left = 0;
    int last_right = 0;
    longint phase_acc = UNITY;

    t_out_frame expected_frames[$];

    int src_gap_pct = 0;      // chance in 100 that the sender idles a cycle
    int sink_stall_pct = 0;   // chance in 100 that the receiver stalls a cycle
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // sample * UNITY in, volume applied, truncated toward zero, clipped to 16 bits
    function automatic t_sample apply_volume(longint value_q);
        longint quo;
        quo = (value_q * longint'(volume_shadow)) / (longint'(100) * UNITY);
        if (quo > 32767)
            quo = 32767;
        if (quo < -32768)
            quo = -32768;
        return t_sample'(quo);
    endfunction

    // Works out every result one accepted request produces and queues them.
    task automatic predict_resampled_frames(input t_sample cur_l, input t_sample cur_r);
        t_out_frame burst[slrv_pkg::MAX_RESULTS];
        longint step;
        int n;
        int a_l;
        int a_r;
        n = 0;
        a_l = int'(cur_l);
        a_r = int'(cur_r);
        // mute wins over bypass; neither touches the resampler state
        if (mute_shadow)
            return;
        if (bypass_shadow) begin
            burst[0].left = apply_volume(longint'(a_l) * UNITY);
            burst[0].right = apply_volume(longint'(a_r) * UNITY);
            burst[0].run_last = 1'b1;
            expected_frames.push_back(burst[0]);
            return;
        end
        step = step_shadow;
        if (step < STEP_FLOOR)
            step = STEP_FLOOR;
        if (step > STEP_CEIL)
            step = STEP_CEIL;
        while (phase_acc < UNITY && n < slrv_pkg::MAX_RESULTS) begin
            burst[n].left = apply_volume(longint'(last_left) * UNITY
                                         + longint'(a_l - last_left) * phase_acc);
            burst[n].right = apply_volume(longint'(last_right) * UNITY
                                          + longint'(a_r - last_right) * phase_acc);
            burst[n].run_last = 1'b0;
            n++;
            phase_acc += step;
        end
        if (n > 0)
            burst[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_frames.push_back(burst[k]);
        // a large step leaves phase above one: the next requests emit nothing
        phase_acc -= UNITY;
        if (phase_acc < 0)
            phase_acc = 0;
        last_left = a_l;
        last_right = a_r;
    endtask

    // ---------------------------------------------------------------
    // Driving: inputs change on the falling edge only
    // ---------------------------------------------------------------

    // one request on the source channel; valid stays high afterward so
    // back-to-back requests need no extra edge
    task automatic send_frame(input t_sample l, input t_sample r, input logic chunk_end);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_src_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_src_valid <= 1'b1;
        i_src_left <= l;
        i_src_right <= r;
        i_chunk_last <= chunk_end;
        do
            @(posedge i_clk);
        while (!(i_src_valid && !o_src_stall));
        predict_resampled_frames(l, r);
    endtask

    // sender holds off until every expected result has left the block,
    // then waits out anything still in flight that produces no result
    task automatic drain_results();
        @(negedge i_clk);
        i_src_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input logic [slrv_pkg::CFG_IDX_W-1:0] idx,
                             input t_cfg_word data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            slrv_pkg::CFG_STEP: step_shadow = longint'(data);
            slrv_pkg::CFG_BYPASS: bypass_shadow = data[0];
            slrv_pkg::CFG_VOLUME: volume_shadow = int'(data[slrv_pkg::VOL_W-1:0]);
            slrv_pkg::CFG_MUTE: mute_shadow = data[0];
            default: ;
        endcase
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: L=%0d R=%0d run_last=%0b",
                             o_out_left, o_out_right, o_run_last);
            end else begin
                want = expected_frames.pop_front();
                if (o_out_left !== want.left || o_out_right !== want.right
                        || o_run_last !== want.run_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected L=%0d R=%0d run_last=%0b, %s",
                                 want.left, want.right, want.run_last,
                                 $sformatf("got L=%0d R=%0d run_last=%0b",
                                           o_out_left, o_out_right, o_run_last));
                end
            end
        end
    end

    // watchdog: too long without any request moving on either channel
    always @(posedge i_clk) begin
        if ((i_src_valid && !o_src_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return t_sample'(32767);
            1: return t_sample'(-32768);
            2: return t_sample'(int'($urandom_range(0, 64)) - 32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // bypass after reset: unity gain, then gain above 100 to hit both clip rails
    task automatic test_bypass_gain();
        send_frame(16'sd32767, -16'sd32768, 1'b1);
        send_frame(-16'sd32768, 16'sd32767, 1'b0);
        send_frame(16'sd0, -16'sd1, 1'b1);
        drain_results();
        write_reg(slrv_pkg::CFG_VOLUME, t_cfg_word'(127));
        send_frame(16'sd32767, -16'sd32768, 1'b0);
        send_frame(-16'sd32768, 16'sd32767, 1'b1);
        drain_results();
    endtask

    // mute drops everything, also over bypass, state untouched
    task automatic test_mute();
        write_reg(slrv_pkg::CFG_MUTE, t_cfg_word'(1));
        send_frame(16'sd1234, -16'sd1234, 1'b0);
        send_frame(16'sd32767, 16'sd32767, 1'b1);
        drain_results();
        write_reg(slrv_pkg::CFG_MUTE, t_cfg_word'(0));
        write_reg(slrv_pkg::CFG_VOLUME, t_cfg_word'(0));
        send_frame(-16'sd32768, 16'sd32767, 1'b0);
        drain_results();
    endtask

    // resampling: unity step, clamped slow step, clamped and exact fast step
    task automatic test_resample_directed();
        write_reg(slrv_pkg::CFG_BYPASS, t_cfg_word'(0));
        write_reg(slrv_pkg::CFG_VOLUME, t_cfg_word'(100));
        write_reg(slrv_pkg::CFG_STEP, t_cfg_word'(UNITY_I));
        // phase starts at one, so the first frame gives nothing
        send_frame(16'sd32767, -16'sd32768, 1'b0);
        send_frame(-16'sd32768, 16'sd32767, 1'b1);
        send_frame(16'sd100, -16'sd100, 1'b0);
        drain_results();
        // step below the floor runs at one sixteenth: sixteen results per frame
        write_reg(slrv_pkg::CFG_STEP, t_cfg_word'(0));
        send_frame(16'sd32767, -16'sd32768, 1'b0);
        send_frame(-16'sd32768, 16'sd32767, 1'b1);
        drain_results();
        // step above the ceiling: most frames emit nothing but still shift prev
        write_reg(slrv_pkg::CFG_STEP, '1);
        send_frame(16'sd5, -16'sd5, 1'b0);
        send_frame(16'sd7, 16'sd7, 1'b1);
        send_frame(16'sd1, 16'sd2, 1'b0);
        drain_results();
        write_reg(slrv_pkg::CFG_STEP, t_cfg_word'(16 * UNITY_I));
        write_reg(slrv_pkg::CFG_VOLUME, t_cfg_word'(127));
        send_frame(-16'sd32768, 16'sd32767, 1'b1);
        send_frame(16'sd32767, -16'sd32768, 1'b0);
        drain_results();
        // muted while resampling: phase and prev frame must hold
        write_reg(slrv_pkg::CFG_MUTE, t_cfg_word'(1));
        send_frame(16'sd999, -16'sd999, 1'b1);
        drain_results();
        write_reg(slrv_pkg::CFG_MUTE, t_cfg_word'(0));
    endtask

    // random settings per block, random frames within; the drain before each
    // block is also where the sender waits for all results to come back
    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        t_cfg_word step_word;
        int vol;
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
            drain_results();
            case ($urandom_range(0, 9))
                0: step_word = t_cfg_word'($urandom_range(0, UNITY_I / 16 - 1));
                1: step_word = t_cfg_word'($urandom_range(16 * UNITY_I + 1, 2097151));
                2: step_word = t_cfg_word'(UNITY_I / 16);
                3: step_word = t_cfg_word'(16 * UNITY_I);
                default: step_word = t_cfg_word'($urandom_range(UNITY_I / 4, 4 * UNITY_I));
            endcase
            case ($urandom_range(0, 5))
                0: vol = 0;
                1: vol = 100;
                2: vol = 127;
                default: vol = $urandom_range(0, 127);
            endcase
            write_reg(slrv_pkg::CFG_STEP, step_word);
            write_reg(slrv_pkg::CFG_BYPASS, t_cfg_word'($urandom_range(0, 4) == 0));
            write_reg(slrv_pkg::CFG_VOLUME, t_cfg_word'(vol));
            write_reg(slrv_pkg::CFG_MUTE, t_cfg_word'($urandom_range(0, 9) == 0));
            for (int f = 0; f < FRAMES_PER_BLOCK; f++)
                send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bypass_gain();
        test_mute();
        test_resample_directed();
        test_random_traffic(0, 0);
        test_random_traffic(62, 0);
        test_random_traffic(0, 62);
        test_random_traffic(10, 10);

        // every request is in; wait for the tail and any stray results
        src_gap_pct = 0;
        sink_stall_pct = 0;
        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
